// ===== sv/yuv_color_adjust_top_assert.svh =====
// ----------------------------------------------------------------------------
// yuv_color_adjust_top_assert.svh
// Assertion macros used by the YUV color adjust RTL.
// ----------------------------------------------------------------------------
`ifndef YUV_COLOR_ADJUST_TOP_ASSERT_SVH
`define YUV_COLOR_ADJUST_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define YCA_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("yca assertion failed");

// Next-cycle implication, checked out of reset
`define YCA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("yca assertion failed");

`endif

// ===== sv/yca_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yca_pkg
// Types, constants and helpers for the YUV color adjust block.
// ----------------------------------------------------------------------------
package yca_pkg;

   // Pixel format
   localparam int PIX_BITS    = 10;
   localparam int PIX_MID_INT = 1 << (PIX_BITS - 1);
   localparam int PIX_MAX_INT = (1 << PIX_BITS) - 1;

   // Width used for intermediate sums ahead of a clamp
   localparam int WIDE_BITS = 16;

   // Register file
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 11;

   localparam logic [CSR_IDX_BITS-1:0] CSR_EFFECT_ENABLE     = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_BRIGHTNESS_OFFSET = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CONTRAST_GAIN     = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SATURATION_GAIN   = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_HUE_COS           = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] CSR_HUE_SIN           = 3'd5;

   // Register reset values
   localparam logic [7:0] SAT_GAIN_RESET = 8'd128;
   localparam logic [7:0] HUE_COS_RESET  = 8'd255;

   typedef struct packed {
      logic [PIX_BITS-1:0] luma_in;
      logic [PIX_BITS-1:0] cb_in;
      logic [PIX_BITS-1:0] cr_in;
   } yca_req_type;

   typedef struct packed {
      logic [PIX_BITS-1:0] luma_out;
      logic [PIX_BITS-1:0] cb_out;
      logic [PIX_BITS-1:0] cr_out;
   } yca_rsp_type;

   // Saturate a signed value to 0..PIX_MAX
   function automatic logic [PIX_BITS-1:0] clamp_pix(input logic signed [WIDE_BITS-1:0] x);
      logic [PIX_BITS-1:0] r;
      if (x[WIDE_BITS-1]) begin
         r = '0;
      end else if (x > WIDE_BITS'(PIX_MAX_INT)) begin
         r = PIX_BITS'(PIX_MAX_INT);
      end else begin
         r = x[PIX_BITS-1:0];
      end
      return r;
   endfunction

   // Offset-binary sample to signed offset about mid scale (c - MID)
   function automatic logic signed [PIX_BITS-1:0] to_offset(input logic [PIX_BITS-1:0] c);
      return $signed({~c[PIX_BITS-1], c[PIX_BITS-2:0]});
   endfunction

endpackage

// ===== sv/yuv_color_adjust_top.sv =====
// A request taken on start appears on rsp_valid/rsp_data once it has passed all five register stages.
// Throughput: one pixel per clock; busy stays low, so start may be high every cycle.
// Five register stages all advance every cycle; the stage count sets the latency.
// Reset: synchronous, active high; clears all stage valid bits and loads the
// register defaults (effect off, saturation 128, hue cosine 255, others 0).
// csr_ready stays high; the result strobe cannot be held off by the receiver.
`timescale 1ns / 1ps
`include "yuv_color_adjust_top_assert.svh"
// ----------------------------------------------------------------------------
// yuv_color_adjust_top
// Brightness, contrast, saturation and hue adjustment of one YUV pixel per clock.
// ----------------------------------------------------------------------------
module yuv_color_adjust_top (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 start,
   output logic                                 busy,
   input  yca_pkg::yca_req_type                 req_data,
   // result channel
   output logic                                 rsp_valid,
   output yca_pkg::yca_rsp_type                 rsp_data,
   // register write channel
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [yca_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  logic [yca_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);
   import yca_pkg::*;

   localparam int NUM_STAGES = 5;
   localparam logic signed [WIDE_BITS-1:0] MID_W   = WIDE_BITS'(PIX_MID_INT);
   localparam logic signed [11:0]          Y_PIVOT = 12'(PIX_MID_INT - 1);

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   logic               enable_ff;
   logic signed [10:0] bright_ff;
   logic signed [8:0]  contrast_ff;
   logic [7:0]         sat_ff;
   logic [7:0]         hue_cos_ff;
   logic [7:0]         hue_sin_ff;

   logic csr_write;
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff   <= 1'b0;
         bright_ff   <= '0;
         contrast_ff <= '0;
         sat_ff      <= SAT_GAIN_RESET;
         hue_cos_ff  <= HUE_COS_RESET;
         hue_sin_ff  <= '0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_EFFECT_ENABLE:     enable_ff   <= csr_wdata[0];
            CSR_BRIGHTNESS_OFFSET: bright_ff   <= $signed(csr_wdata[10:0]);
            CSR_CONTRAST_GAIN:     contrast_ff <= $signed(csr_wdata[8:0]);
            CSR_SATURATION_GAIN:   sat_ff      <= csr_wdata[7:0];
            CSR_HUE_COS:           hue_cos_ff  <= csr_wdata[7:0];
            CSR_HUE_SIN:           hue_sin_ff  <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Handshake and valid pipeline
   // ---------------------------------------------------------------------
   logic                  req_take;
   logic [NUM_STAGES-1:0] vld_ff;
   logic [NUM_STAGES-1:0] vld_in;

   assign busy     = 1'b0;
   assign req_take = start && !busy;
   assign vld_in   = {vld_ff[NUM_STAGES-2:0], req_take};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // Raw pixel and per-request enable ride along for pass-through
   yca_req_type pix_ff [NUM_STAGES-1];
   logic        en_ff  [NUM_STAGES-1];

   always_ff @(posedge clock) begin
      pix_ff[0] <= req_data;
      en_ff[0]  <= enable_ff;
      for (int i = 1; i < NUM_STAGES - 1; i++) begin
         pix_ff[i] <= pix_ff[i-1];
         en_ff[i]  <= en_ff[i-1];
      end
   end

   // ---------------------------------------------------------------------
   // Stage 1: brightness with floor at zero, chroma to signed offsets
   // ---------------------------------------------------------------------
   logic signed [11:0]         y_sum;
   logic [10:0]                y1_in;
   logic [10:0]                y1_ff;
   logic signed [PIX_BITS-1:0] du1_ff;
   logic signed [PIX_BITS-1:0] dv1_ff;

   assign y_sum = $signed({2'b00, req_data.luma_in}) + 12'(bright_ff);
   assign y1_in = y_sum[11] ? '0 : y_sum[10:0];

   always_ff @(posedge clock) begin
      y1_ff  <= y1_in;
      du1_ff <= to_offset(req_data.cb_in);
      dv1_ff <= to_offset(req_data.cr_in);
   end

   // ---------------------------------------------------------------------
   // Stage 2: contrast and saturation products
   // ---------------------------------------------------------------------
   logic signed [11:0] dy;
   logic signed [8:0]  sat_s;
   logic signed [20:0] cprod_in;
   logic signed [18:0] su_in;
   logic signed [18:0] sv_in;
   logic signed [20:0] cprod_ff;
   logic signed [18:0] su_ff;
   logic signed [18:0] sv_ff;
   logic [10:0]        y2_ff;

   assign dy       = $signed({1'b0, y1_ff}) - Y_PIVOT;
   assign sat_s    = $signed({1'b0, sat_ff});
   assign cprod_in = dy * contrast_ff;
   assign su_in    = du1_ff * sat_s;
   assign sv_in    = dv1_ff * sat_s;

   always_ff @(posedge clock) begin
      cprod_ff <= cprod_in;
      su_ff    <= su_in;
      sv_ff    <= sv_in;
      y2_ff    <= y1_ff;
   end

   // ---------------------------------------------------------------------
   // Stage 3: finish luma, clamp scaled chroma
   // ---------------------------------------------------------------------
   logic signed [WIDE_BITS-1:0] y3_sum;
   logic signed [WIDE_BITS-1:0] u3_sum;
   logic signed [WIDE_BITS-1:0] v3_sum;
   logic [PIX_BITS-1:0]         y3_ff;
   logic signed [PIX_BITS-1:0]  du3_ff;
   logic signed [PIX_BITS-1:0]  dv3_ff;

   assign y3_sum = $signed({5'b0, y2_ff}) + WIDE_BITS'($signed(cprod_ff[20:7]));
   assign u3_sum = WIDE_BITS'($signed(su_ff[18:7])) + MID_W;
   assign v3_sum = WIDE_BITS'($signed(sv_ff[18:7])) + MID_W;

   always_ff @(posedge clock) begin
      y3_ff  <= clamp_pix(y3_sum);
      du3_ff <= to_offset(clamp_pix(u3_sum));
      dv3_ff <= to_offset(clamp_pix(v3_sum));
   end

   // ---------------------------------------------------------------------
   // Stage 4: hue mix products
   // ---------------------------------------------------------------------
   logic signed [8:0]  hc_s;
   logic signed [8:0]  hs_s;
   logic signed [17:0] uc_ff;
   logic signed [17:0] vs_ff;
   logic signed [17:0] vc_ff;
   logic signed [17:0] us_ff;
   logic [PIX_BITS-1:0] y4_ff;

   assign hc_s = $signed({1'b0, hue_cos_ff});
   assign hs_s = $signed({1'b0, hue_sin_ff});

   always_ff @(posedge clock) begin
      uc_ff <= du3_ff * hc_s;
      vs_ff <= dv3_ff * hs_s;
      vc_ff <= dv3_ff * hc_s;
      us_ff <= du3_ff * hs_s;
      y4_ff <= y3_ff;
   end

   // ---------------------------------------------------------------------
   // Stage 5: sum, shift, recenter, clamp; pass-through select
   // ---------------------------------------------------------------------
   logic signed [18:0]          u_mix;
   logic signed [18:0]          v_mix;
   logic signed [WIDE_BITS-1:0] u5_sum;
   logic signed [WIDE_BITS-1:0] v5_sum;
   yca_rsp_type                 adj_px;
   yca_rsp_type                 rsp_in;
   yca_rsp_type                 rsp_ff;
   yca_req_type                 raw_px;

   assign u_mix  = 19'(uc_ff) + 19'(vs_ff);
   assign v_mix  = 19'(vc_ff) + 19'(us_ff);
   assign u5_sum = WIDE_BITS'($signed(u_mix[18:8])) + MID_W;
   assign v5_sum = WIDE_BITS'($signed(v_mix[18:8])) + MID_W;
   assign raw_px = pix_ff[NUM_STAGES-2];

   always_comb begin
      adj_px.luma_out = y4_ff;
      adj_px.cb_out   = clamp_pix(u5_sum);
      adj_px.cr_out   = clamp_pix(v5_sum);
      if (en_ff[NUM_STAGES-2]) begin
         rsp_in = adj_px;
      end else begin
         rsp_in.luma_out = raw_px.luma_in;
         rsp_in.cb_out   = raw_px.cb_in;
         rsp_in.cr_out   = raw_px.cr_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = vld_ff[NUM_STAGES-1];
   assign rsp_data  = rsp_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   `YCA_ASSERT_SAME(a_rsp_from_req, clock, reset, rsp_valid, $past(req_take, 5))
   `YCA_ASSERT_SAME(a_bypass_exact, clock, reset, rsp_valid && !$past(enable_ff, 5), rsp_data.luma_out == $past(req_data.luma_in, 5) && rsp_data.cb_out == $past(req_data.cb_in, 5) && rsp_data.cr_out == $past(req_data.cr_in, 5))
   `YCA_ASSERT_NEXT(a_vld_mid_shift, clock, reset, vld_ff[1], vld_ff[2])

endmodule

// ===== dv/yuv_color_adjust_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yuv_color_adjust_top_tb
// Self-checking bench for the YUV brightness/contrast/saturation/hue block.
// Every accepted pixel request is run through a local fixed-point model.
// The model keeps its own copy of the control registers. Each strobed result
// is checked field by field against the oldest pending prediction. Stimulus
// starts with directed corner settings and pixels. It then runs random
// register settings with random pixels and random request gaps.
// ----------------------------------------------------------------------------
module yuv_color_adjust_top_tb;
   import yca_pkg::*;

   localparam int CONTRAST_SHIFT = 7;
   localparam int SAT_SHIFT      = 7;
   localparam int HUE_SHIFT      = 8;
   localparam int RAND_PHASES    = 19;
   localparam int PHASE_PIXELS   = 100;
   localparam int DRAIN_CYCLES   = 10;

   // Indexes with no register behind them; writes there must be dropped
   localparam logic [CSR_IDX_BITS-1:0] CSR_SPARE_A = 3'd6;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SPARE_B = 3'd7;

   // ------------------------------------------------------------------------
   // Scoreboard: register shadow, pixel predictor, expected result queue
   // ------------------------------------------------------------------------
   class color_adjust_scoreboard;
      logic                     fx_on;
      logic signed [10:0]       bright;
      logic signed [8:0]        contrast;
      logic [7:0]               sat_gain;
      logic [7:0]               hue_c;
      logic [7:0]               hue_s;
      yca_rsp_type              expected_pixels[$];
      int unsigned              failures;
      int unsigned              checked;

      function new();
         fx_on    = 1'b0;
         bright   = '0;
         contrast = '0;
         sat_gain = SAT_GAIN_RESET;
         hue_c    = HUE_COS_RESET;
         hue_s    = '0;
         failures = 0;
         checked  = 0;
      endfunction

      // Register write; data bits above each register's width are dropped
      function void write_reg(logic [CSR_IDX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] wdata);
         case (idx)
            CSR_EFFECT_ENABLE:     fx_on    = wdata[0];
            CSR_BRIGHTNESS_OFFSET: bright   = wdata[10:0];
            CSR_CONTRAST_GAIN:     contrast = wdata[8:0];
            CSR_SATURATION_GAIN:   sat_gain = wdata[7:0];
            CSR_HUE_COS:           hue_c    = wdata[7:0];
            CSR_HUE_SIN:           hue_s    = wdata[7:0];
            default: ;
         endcase
      endfunction

      function logic [PIX_BITS-1:0] clip(int x);
         if (x < 0) return '0;
         if (x > PIX_MAX_INT) return PIX_BITS'(PIX_MAX_INT);
         return PIX_BITS'(x);
      endfunction

      // Full-precision pixel math; >>> on int floors toward minus infinity
      function yca_rsp_type adjust_pixel(yca_req_type px);
         yca_rsp_type r;
         int          y;
         int          su;
         int          sv;
         int          mu;
         int          mv;
         r.luma_out = px.luma_in;
         r.cb_out   = px.cb_in;
         r.cr_out   = px.cr_in;
         if (!fx_on) return r;
         // luma: offset, floor at zero (no upper clamp yet), contrast about mid-1
         y = int'(px.luma_in) + int'(bright);
         if (y < 0) y = 0;
         y = y + (((y - (PIX_MID_INT - 1)) * int'(contrast)) >>> CONTRAST_SHIFT);
         // chroma gain about mid, clamped before the hue mix
         su = int'(clip((((int'(px.cb_in) - PIX_MID_INT) * int'(sat_gain)) >>> SAT_SHIFT)
                        + PIX_MID_INT));
         sv = int'(clip((((int'(px.cr_in) - PIX_MID_INT) * int'(sat_gain)) >>> SAT_SHIFT)
                        + PIX_MID_INT));
         // hue mix by cos/sin weights
         mu = ((((su - PIX_MID_INT) * int'(hue_c)) + ((sv - PIX_MID_INT) * int'(hue_s)))
               >>> HUE_SHIFT) + PIX_MID_INT;
         mv = ((((sv - PIX_MID_INT) * int'(hue_c)) + ((su - PIX_MID_INT) * int'(hue_s)))
               >>> HUE_SHIFT) + PIX_MID_INT;
         r.luma_out = clip(y);
         r.cb_out   = clip(mu);
         r.cr_out   = clip(mv);
         return r;
      endfunction

      function void note_request(yca_req_type px);
         expected_pixels.push_back(adjust_pixel(px));
      endfunction

      function void check_result(yca_rsp_type got);
         yca_rsp_type want;
         if (expected_pixels.size() == 0) begin
            $error("result with no pending request: luma %0d cb %0d cr %0d",
                   got.luma_out, got.cb_out, got.cr_out);
            failures++;
            return;
         end
         want = expected_pixels.pop_front();
         checked++;
         if (got.luma_out !== want.luma_out) begin
            $error("luma_out mismatch: expected %0d, actual %0d", want.luma_out, got.luma_out);
            failures++;
         end
         if (got.cb_out !== want.cb_out) begin
            $error("cb_out mismatch: expected %0d, actual %0d", want.cb_out, got.cb_out);
            failures++;
         end
         if (got.cr_out !== want.cr_out) begin
            $error("cr_out mismatch: expected %0d, actual %0d", want.cr_out, got.cr_out);
            failures++;
         end
      endfunction

      function int pending();
         return expected_pixels.size();
      endfunction
   endclass

   // ------------------------------------------------------------------------
   // DUT hookup
   // ------------------------------------------------------------------------
   logic                     clock;
   logic                     reset;
   logic                     start;
   logic                     busy;
   yca_req_type              req_data;
   logic                     rsp_valid;
   yca_rsp_type              rsp_data;
   logic                     csr_valid;
   logic                     csr_ready;
   logic [CSR_IDX_BITS-1:0]  csr_index;
   logic [CSR_DATA_BITS-1:0] csr_wdata;

   color_adjust_scoreboard color_sb = new();
   int unsigned            n_settings = 0;
   int unsigned            n_enabled  = 0;

   yuv_color_adjust_top u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Run limit, well past the slowest legal run
   initial begin
      #6_000_000;
      $display("FAILURE");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Monitor: register writes, accepted requests, result strobes
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) color_sb.write_reg(csr_index, csr_wdata);
         if (start && !busy) color_sb.note_request(req_data);
         if (rsp_valid) color_sb.check_result(rsp_data);
      end
   end

   // ------------------------------------------------------------------------
   // Driver tasks
   // ------------------------------------------------------------------------
   function automatic yca_req_type make_px(int y, int u, int v);
      yca_req_type px;
      px.luma_in = PIX_BITS'(y);
      px.cb_in   = PIX_BITS'(u);
      px.cr_in   = PIX_BITS'(v);
      return px;
   endfunction

   // Mostly random, with a fair share of zero, mid and full scale
   function automatic logic [PIX_BITS-1:0] pick_sample();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return PIX_BITS'(PIX_MAX_INT);
         2:       return PIX_BITS'(PIX_MID_INT);
         default: return PIX_BITS'($urandom);
      endcase
   endfunction

   // Register value: low end, high end, or anywhere in between
   function automatic int pick_value(int lo, int hi);
      case ($urandom_range(0, 3))
         0:       return lo;
         1:       return hi;
         default: return lo + int'($urandom_range(0, hi - lo));
      endcase
   endfunction

   // Gap length: mostly none, some short, a few long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Leaves start high on return; the caller lowers it or sends again
   task automatic send_pixel(input yca_req_type px);
      start    <= 1'b1;
      req_data <= px;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic hold_off(input int cycles);
      if (cycles > 0) begin
         start <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   // Stop sending and wait until every predicted pixel has come back
   task automatic wait_drain();
      start <= 1'b0;
      @(negedge clock);
      while (color_sb.pending() != 0) @(negedge clock);
      @(posedge clock);
   endtask

   // One register write; random junk above the register width
   task automatic csr_write(input logic [CSR_IDX_BITS-1:0] idx, input int value,
                            input int width);
      logic [CSR_DATA_BITS-1:0] mask;
      logic [CSR_DATA_BITS-1:0] w;
      int                       gap;
      mask = CSR_DATA_BITS'((1 << width) - 1);
      w    = (CSR_DATA_BITS'($urandom) & ~mask) | (CSR_DATA_BITS'(value) & mask);
      gap  = $urandom_range(0, 3);
      if (gap > 1) begin
         csr_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= w;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   // Full register setting; only called with the pipeline empty
   task automatic apply_setting(input int en, input int br, input int ct, input int sat,
                                input int hc, input int hs);
      csr_write(CSR_EFFECT_ENABLE, en, 1);
      csr_write(CSR_BRIGHTNESS_OFFSET, br, 11);
      csr_write(CSR_CONTRAST_GAIN, ct, 9);
      csr_write(CSR_SATURATION_GAIN, sat, 8);
      csr_write(CSR_HUE_COS, hc, 8);
      csr_write(CSR_HUE_SIN, hs, 8);
      csr_write(CSR_SPARE_A, int'($urandom), CSR_DATA_BITS);
      csr_write(CSR_SPARE_B, int'($urandom), CSR_DATA_BITS);
      csr_valid <= 1'b0;
      n_settings++;
      if (en[0]) n_enabled++;
   endtask

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin
      bit gappy;
      reset     <= 1'b1;
      start     <= 1'b0;
      req_data  <= '0;
      csr_valid <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset defaults: effect off, pixels pass through
      send_pixel(make_px(0, 0, 0));
      send_pixel(make_px(PIX_MAX_INT, PIX_MAX_INT, PIX_MAX_INT));
      send_pixel(make_px(PIX_MID_INT, 0, PIX_MAX_INT));
      wait_drain();

      // Luma pushed past full scale, strongest negative contrast, max chroma gain and mix
      apply_setting(1, 1023, -256, 255, 255, 255);
      send_pixel(make_px(PIX_MAX_INT, 0, PIX_MAX_INT));
      send_pixel(make_px(0, PIX_MAX_INT, 0));
      send_pixel(make_px(PIX_MAX_INT, PIX_MAX_INT, PIX_MAX_INT));
      send_pixel(make_px(PIX_MID_INT, PIX_MID_INT, PIX_MID_INT));
      wait_drain();

      // Most negative offset, max positive contrast, chroma and hue weights at zero
      apply_setting(1, -1024, 255, 0, 0, 0);
      send_pixel(make_px(0, 0, 0));
      send_pixel(make_px(PIX_MAX_INT, PIX_MAX_INT, PIX_MAX_INT));
      send_pixel(make_px(511, 200, 900));
      wait_drain();

      // Near identity settings
      apply_setting(1, 0, 0, 128, 255, 0);
      send_pixel(make_px(511, PIX_MID_INT, PIX_MID_INT));
      send_pixel(make_px(1000, 10, 1000));
      send_pixel(make_px(3, 777, 250));
      wait_drain();

      // Pure sine mix with full gain and max offset
      apply_setting(1, 1023, 255, 255, 0, 255);
      send_pixel(make_px(PIX_MAX_INT, 0, 0));
      send_pixel(make_px(0, PIX_MAX_INT, PIX_MAX_INT));
      send_pixel(make_px(600, 300, 700));
      wait_drain();

      // Effect off with non-default gains still passes through
      apply_setting(0, -1, -1, 0, 0, 255);
      send_pixel(make_px(PIX_MAX_INT, 0, PIX_MID_INT));
      wait_drain();

      // Random settings, each followed by a burst of random pixels
      for (int ph = 0; ph < RAND_PHASES; ph++) begin
         apply_setting(($urandom_range(0, 7) != 0), pick_value(-1024, 1023),
                       pick_value(-256, 255), pick_value(0, 255), pick_value(0, 255),
                       pick_value(0, 255));
         gappy = (ph % 3 != 0);
         for (int i = 0; i < PHASE_PIXELS; i++) begin
            send_pixel(make_px(pick_sample(), pick_sample(), pick_sample()));
            if (gappy) hold_off(pick_gap());
            // sender stalls until the pipeline has fully emptied
            if (i == PHASE_PIXELS / 2 && ph % 4 == 1) wait_drain();
         end
         wait_drain();
      end

      // Catch any stray strobe after the last result
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Checked %0d pixels over %0d register settings, %0d with the effect on.",
               color_sb.checked, n_settings, n_enabled);
      $display("Writes hit unmapped indexes and junk upper data bits; gain extremes covered.");
      if (color_sb.failures == 0 && color_sb.pending() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/yca_pkg.sv
sv/yuv_color_adjust_top.sv
dv/yuv_color_adjust_top_tb.sv
